// ===== src/quadratic_root_solver_defines.svh =====
// Assertion macros shared by the quadratic root solver RTL.
// Depends on clk and rst being visible in the module that uses them.
`ifndef QUADRATIC_ROOT_SOLVER_DEFINES_SVH
`define QUADRATIC_ROOT_SOLVER_DEFINES_SVH
`ifndef SYNTHESIS
`define QRS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define QRS_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define QRS_ASSERT(lbl, prop, msg)
`define QRS_NEVER(lbl, expr, msg)
`endif
`endif

// ===== src/qrs_pkg.sv =====
// Shared widths, item kinds, root counts and the queue item type.
// No dependencies.
package qrs_pkg;

  localparam int CoefW   = 16;
  localparam int DiscW   = 34;
  localparam int RootW   = 17;
  localparam int MagW    = 17;
  localparam int QuoW    = 33;
  localparam int OutW    = 32;
  localparam int QDepth  = 4;
  localparam int QIdxW   = 2;
  localparam int QCntW   = 3;
  localparam int SqSteps = 17;
  localparam int DivSteps = 33;

  localparam logic [2:0] KIND_NONE = 3'd0;
  localparam logic [2:0] KIND_INF  = 3'd1;
  localparam logic [2:0] KIND_LIN  = 3'd2;
  localparam logic [2:0] KIND_ONE  = 3'd3;
  localparam logic [2:0] KIND_TWO  = 3'd4;

  localparam logic [1:0] CNT_NONE = 2'd0;
  localparam logic [1:0] CNT_ONE  = 2'd1;
  localparam logic [1:0] CNT_TWO  = 2'd2;
  localparam logic [1:0] CNT_INF  = 2'd3;

  typedef struct packed {
    logic [2:0]              kind;
    logic signed [CoefW-1:0] a;
    logic signed [CoefW-1:0] b;
    logic signed [CoefW-1:0] c;
    logic [DiscW-1:0]        d;
  } item_t;

  typedef struct packed {
    logic [QCntW-1:0] count;
    logic             empty;
  } qstat_t;

endpackage

// ===== src/qrs_front.sv =====
// Front end: registers coefficients, forms the discriminant, classifies.
// Depends on qrs_pkg.
module qrs_front import qrs_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [CoefW-1:0] coef_quad,
  input  logic signed [CoefW-1:0] coef_lin,
  input  logic signed [CoefW-1:0] coef_const,
  input  qstat_t                  qstat,
  output logic                    busy,
  output logic                    push,
  output item_t                   push_item
);

  logic                    v1, v2;
  logic signed [CoefW-1:0] a1, b1, c1, a2, b2, c2;
  logic signed [31:0]      bb2, ac2;
  logic [QCntW:0]          load;
  logic signed [34:0]      d;

  // Reserve a queue slot for every item in flight.
  assign load = {1'b0, qstat.count} + {{QCntW{1'b0}}, v1} + {{QCntW{1'b0}}, v2};
  assign busy = load >= (QCntW+1)'(QDepth);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= start && !busy;
      v2 <= v1;
    end
    a1  <= coef_quad;
    b1  <= coef_lin;
    c1  <= coef_const;
    a2  <= a1;
    b2  <= b1;
    c2  <= c1;
    bb2 <= b1 * b1;
    ac2 <= a1 * c1;
  end

  assign d = {{3{bb2[31]}}, bb2} - {ac2[31], ac2, 2'b00};

  always_comb begin
    push_item   = '0;
    push_item.a = a2;
    push_item.b = b2;
    push_item.c = c2;
    if (a2 == '0) begin
      if (b2 == '0) begin
        push_item.kind = (c2 == '0) ? KIND_INF : KIND_NONE;
      end else begin
        push_item.kind = KIND_LIN;
      end
    end else if (d[34]) begin
      push_item.kind = KIND_NONE;
    end else begin
      push_item.d    = d[DiscW-1:0];
      push_item.kind = (d == '0) ? KIND_ONE : KIND_TWO;
    end
  end

  assign push = v2;

endmodule

// ===== src/qrs_queue.sv =====
// Short queue between front and back; drains one item per cycle whenever it holds one.
// Depends on qrs_pkg and the assertion macro header.
`include "quadratic_root_solver_defines.svh"
module qrs_queue import qrs_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  item_t  push_item,
  output qstat_t qstat,
  output logic   pop,
  output item_t  pop_item
);

  item_t            mem [QDepth];
  logic [QIdxW-1:0] wr_ptr, rd_ptr;
  logic [QCntW-1:0] count;

  assign pop         = count != '0;
  assign pop_item    = mem[rd_ptr];
  assign qstat.count = count;
  assign qstat.empty = !pop;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + {{(QCntW-1){1'b0}}, push} - {{(QCntW-1){1'b0}}, pop};
    end
  end

  `QRS_NEVER(a_no_overflow, push && count == QCntW'(QDepth) && !pop, "queue overflow")
  `QRS_ASSERT(a_ptr_count, (wr_ptr - rd_ptr) == count[QIdxW-1:0], "queue count mismatch")

endmodule

// ===== src/qrs_back.sv =====
// Back end: pipelined square root, two pipelined dividers, saturation.
// Depends on qrs_pkg and the assertion macro header.
`include "quadratic_root_solver_defines.svh"
module qrs_back import qrs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  pop,
  input  item_t                 pop_item,
  output logic                  done,
  output logic [1:0]            root_count,
  output logic signed [OutW-1:0] root_first,
  output logic signed [OutW-1:0] root_second
);

  // Square root pipeline, one result bit per stage.
  logic             sq_vld  [SqSteps+1];
  item_t            sq_item [SqSteps+1];
  logic [DiscW-1:0] sq_rad  [SqSteps+1];
  logic [19:0]      sq_rem  [SqSteps+1];
  logic [RootW-1:0] sq_root [SqSteps+1];

  always_ff @(posedge clk) begin
    if (rst) sq_vld[0] <= 1'b0;
    else     sq_vld[0] <= pop;
    sq_item[0] <= pop_item;
    sq_rad[0]  <= pop_item.d;
    sq_rem[0]  <= '0;
    sq_root[0] <= '0;
  end

  for (genvar k = 0; k < SqSteps; k++) begin : g_sq
    logic [19:0] rem_sh, trial;
    logic        ge;
    assign rem_sh = {sq_rem[k][17:0], sq_rad[k][DiscW-1:DiscW-2]};
    assign trial  = {1'b0, sq_root[k], 2'b01};
    assign ge     = rem_sh >= trial;
    always_ff @(posedge clk) begin
      if (rst) sq_vld[k+1] <= 1'b0;
      else     sq_vld[k+1] <= sq_vld[k];
      sq_item[k+1] <= sq_item[k];
      sq_rad[k+1]  <= {sq_rad[k][DiscW-3:0], 2'b00};
      sq_rem[k+1]  <= ge ? rem_sh - trial : rem_sh;
      sq_root[k+1] <= {sq_root[k][RootW-2:0], ge};
    end
  end

  // Numerators and denominator as signed values; the divider takes them as sign and magnitude.
  item_t            it;
  logic signed [17:0] b18, s18, n1, n2, nn1, nn2;
  logic signed [16:0] den, nden;
  logic               lin;

  assign it   = sq_item[SqSteps];
  assign lin  = it.kind == KIND_LIN;
  assign b18  = {{2{it.b[CoefW-1]}}, it.b};
  assign s18  = {1'b0, sq_root[SqSteps]};
  assign n1   = lin ? -{{2{it.c[CoefW-1]}}, it.c} : -b18 - s18;
  assign n2   = s18 - b18;
  assign den  = lin ? {it.b[CoefW-1], it.b} : {it.a, 1'b0};
  assign nn1  = -n1;
  assign nn2  = -n2;
  assign nden = -den;

  // Divider pipeline, two lanes, one quotient bit per stage.
  logic             dv_vld  [DivSteps+1];
  logic [2:0]       dv_kind [DivSteps+1];
  logic             dv_neg  [DivSteps+1][2];
  logic [MagW-1:0]  dv_den  [DivSteps+1];
  logic [QuoW-1:0]  dv_dvd  [DivSteps+1][2];
  logic [MagW-1:0]  dv_rem  [DivSteps+1][2];
  logic [QuoW-1:0]  dv_quo  [DivSteps+1][2];

  always_ff @(posedge clk) begin
    if (rst) dv_vld[0] <= 1'b0;
    else     dv_vld[0] <= sq_vld[SqSteps];
    dv_kind[0]   <= it.kind;
    dv_den[0]    <= den[16] ? nden : den;
    dv_neg[0][0] <= n1[17] ^ den[16];
    dv_neg[0][1] <= n2[17] ^ den[16];
    dv_dvd[0][0] <= {(n1[17] ? nn1[MagW-1:0] : n1[MagW-1:0]), 16'h0000};
    dv_dvd[0][1] <= {(n2[17] ? nn2[MagW-1:0] : n2[MagW-1:0]), 16'h0000};
    dv_rem[0][0] <= '0;
    dv_rem[0][1] <= '0;
    dv_quo[0][0] <= '0;
    dv_quo[0][1] <= '0;
  end

  for (genvar k = 0; k < DivSteps; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (rst) dv_vld[k+1] <= 1'b0;
      else     dv_vld[k+1] <= dv_vld[k];
      dv_kind[k+1] <= dv_kind[k];
      dv_den[k+1]  <= dv_den[k];
    end
    for (genvar j = 0; j < 2; j++) begin : g_lane
      logic [MagW:0] rem_sh, dsr, diff;
      logic          ge;
      assign rem_sh = {dv_rem[k][j], dv_dvd[k][j][QuoW-1]};
      assign dsr    = {1'b0, dv_den[k]};
      assign diff   = rem_sh - dsr;
      assign ge     = rem_sh >= dsr;
      always_ff @(posedge clk) begin
        dv_neg[k+1][j] <= dv_neg[k][j];
        dv_dvd[k+1][j] <= {dv_dvd[k][j][QuoW-2:0], 1'b0};
        dv_rem[k+1][j] <= ge ? diff[MagW-1:0] : rem_sh[MagW-1:0];
        dv_quo[k+1][j] <= {dv_quo[k][j][QuoW-2:0], ge};
      end
    end
  end

  function automatic logic [OutW-1:0] sat_root(input logic neg, input logic [QuoW-1:0] mag);
    logic [QuoW-1:0] nmag;
    nmag = -mag;
    if (!neg) begin
      sat_root = (mag > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : mag[OutW-1:0];
    end else begin
      sat_root = (mag > 33'h0_8000_0000) ? 32'h8000_0000 : nmag[OutW-1:0];
    end
  endfunction

  logic [OutW-1:0] r1, r2;
  assign r1 = sat_root(dv_neg[DivSteps][0], dv_quo[DivSteps][0]);
  assign r2 = sat_root(dv_neg[DivSteps][1], dv_quo[DivSteps][1]);

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= dv_vld[DivSteps];
    unique case (dv_kind[DivSteps])
      KIND_INF: begin
        root_count  <= CNT_INF;
        root_first  <= '0;
        root_second <= '0;
      end
      KIND_LIN, KIND_ONE: begin
        root_count  <= CNT_ONE;
        root_first  <= r1;
        root_second <= r1;
      end
      KIND_TWO: begin
        root_count  <= CNT_TWO;
        root_first  <= r1;
        root_second <= r2;
      end
      default: begin
        root_count  <= CNT_NONE;
        root_first  <= '0;
        root_second <= '0;
      end
    endcase
  end

  logic empty_res;
  assign empty_res = done && (root_count == CNT_NONE || root_count == CNT_INF);

  `QRS_ASSERT(a_none_zero, empty_res |-> root_first == '0 && root_second == '0, "empty result has roots")
  `QRS_ASSERT(a_one_equal, done && root_count == CNT_ONE |-> root_first == root_second, "single root differs")

endmodule

// ===== src/quadratic_root_solver.sv =====
// Top level of the quadratic root solver: front, queue, back.
// Depends on qrs_pkg, qrs_front, qrs_queue and qrs_back.
//
//   channel  | handshake        | payload
//   ---------+------------------+------------------------------------------
//   input    | start, busy      | coef_quad, coef_lin, coef_const (Q8.8)
//   result   | done (strobe)    | root_count, root_first, root_second
//
// One item per cycle is taken while busy is low; each input transfer yields
// one result via the front end, the queue, 18 square root stages (load, then
// a root bit each), 34 divider stages (load, a quotient bit each), output.
// Synchronous active-high rst clears all valid bits and the queue pointers.
// The receiver cannot stall; busy rises only if the queue cannot reserve a
// slot for the new item, which the always-draining back end prevents.
module quadratic_root_solver import qrs_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [CoefW-1:0] coef_quad,
  input  logic signed [CoefW-1:0] coef_lin,
  input  logic signed [CoefW-1:0] coef_const,
  output logic                    done,
  output logic [1:0]              root_count,
  output logic signed [OutW-1:0]  root_first,
  output logic signed [OutW-1:0]  root_second
);

  qstat_t qstat;
  logic   push, pop;
  item_t  push_item, pop_item;

  // Classify and form the discriminant.
  qrs_front u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .coef_quad  (coef_quad),
    .coef_lin   (coef_lin),
    .coef_const (coef_const),
    .qstat      (qstat),
    .busy       (busy),
    .push       (push),
    .push_item  (push_item)
  );

  // Hold classified items until the back end takes them.
  qrs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .qstat     (qstat),
    .pop       (pop),
    .pop_item  (pop_item)
  );

  // Advance through square root and division, then saturate.
  qrs_back u_back (
    .clk         (clk),
    .rst         (rst),
    .pop         (pop),
    .pop_item    (pop_item),
    .done        (done),
    .root_count  (root_count),
    .root_first  (root_first),
    .root_second (root_second)
  );

endmodule
